### src/pfkp_pkg.sv
// Package for the packet flow key parser: parse phases, verdicts, EtherType and protocol codes, item types.
// No dependencies.
`timescale 1ns / 1ps
package pfkp_pkg;

  localparam int unsigned MaxVlanTagsDef = 2;
  localparam int unsigned MaxIpv6ExtDef  = 8;

  typedef enum logic [9:0] {
    PH_ETH    = 10'b0000000001,
    PH_VLAN   = 10'b0000000010,
    PH_V4     = 10'b0000000100,
    PH_V4OPT  = 10'b0000001000,
    PH_V6     = 10'b0000010000,
    PH_V6FRAG = 10'b0000100000,
    PH_V6EXT  = 10'b0001000000,
    PH_L4     = 10'b0010000000,
    PH_DONE   = 10'b0100000000,
    PH_REJECT = 10'b1000000000
  } phase_e;

  localparam logic [1:0] VerdictPorts   = 2'd0;
  localparam logic [1:0] VerdictNoPorts = 2'd1;
  localparam logic [1:0] VerdictReject  = 2'd2;

  localparam logic [15:0] EtVlan  = 16'h8100;
  localparam logic [15:0] EtQinq  = 16'h88A8;
  localparam logic [15:0] EtIpv4  = 16'h0800;
  localparam logic [15:0] EtIpv6  = 16'h86DD;

  localparam logic [7:0] ProtoHop  = 8'd0;
  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;
  localparam logic [7:0] ProtoRout = 8'd43;
  localparam logic [7:0] ProtoFrag = 8'd44;
  localparam logic [7:0] ProtoGre  = 8'd47;
  localparam logic [7:0] ProtoEsp  = 8'd50;
  localparam logic [7:0] ProtoAh   = 8'd51;
  localparam logic [7:0] ProtoDst  = 8'd60;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] interface_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [2:0]  ip_ver;
    logic [7:0]  protocol;
    logic [63:0] src_addr_high;
    logic [63:0] src_addr_low;
    logic [63:0] dst_addr_high;
    logic [63:0] dst_addr_low;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  tcp_flag_bits;
    logic [31:0] frame_interface;
    logic [15:0] frame_len;
  } out_item_t;

endpackage

### src/pfkp_if.sv
// Valid/ready channel interfaces, each carrying one payload struct.
// Depends on pfkp_pkg.
`timescale 1ns / 1ps
interface pfkp_in_if;
  logic valid;
  logic ready;
  pfkp_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface pfkp_out_if;
  logic valid;
  logic ready;
  pfkp_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### src/pfkp_core.sv
// Per-byte parse state machine: updates frame state and builds the result item.
// Depends on pfkp_pkg.
`timescale 1ns / 1ps
module pfkp_core #(
  parameter int unsigned MaxVlanTags = pfkp_pkg::MaxVlanTagsDef,
  parameter int unsigned MaxIpv6Ext  = pfkp_pkg::MaxIpv6ExtDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  pfkp_pkg::in_item_t  item_i,
  output logic                res_valid_o,
  output pfkp_pkg::out_item_t res_o
);
  import pfkp_pkg::*;

  localparam logic [4:0] VlanLim = 5'(MaxVlanTags);
  localparam logic [4:0] ExtLim  = 5'(MaxIpv6Ext);

  phase_e      phase_q, phase_d;
  logic [15:0] pos_q, pos_d, hend_q, hend_d, hstart_q, hstart_d, pnh_q, pnh_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [63:0] addr_q [4];
  logic [63:0] addr_d [4];
  logic [39:0] pf_q, pf_d;
  logic        kv6_q, kv6_d, kports_q, kports_d;
  logic [7:0]  kproto_q, kproto_d, sb_q, sb_d;
  logic [15:0] sw_q, sw_d;
  logic [31:0] intf_q, intf_d;

  logic [15:0] nxt, off, et;
  logic [7:0]  b, nh, proto_f;
  logic [5:0]  ihl;
  logic [11:0] elen;
  logic [1:0]  verdict;
  logic        ports;
  logic [2:0]  bsel;
  logic [4:0]  o8, o24;

  always_comb begin
    b       = item_i.data_byte;
    nxt     = pos_q + 16'd1;
    off     = (pos_q >= hstart_q) ? pos_q - hstart_q : 16'd0;
    phase_d = phase_q;  hend_d = hend_q;  hstart_d = hstart_q;  pnh_d = pnh_q;
    cnt_d   = cnt_q;    pf_d = pf_q;      kv6_d = kv6_q;        kports_d = kports_q;
    kproto_d = kproto_q; sb_d = sb_q;     sw_d = sw_q;
    intf_d  = (pos_q == 16'd0) ? item_i.interface_index : intf_q;
    for (int i = 0; i < 4; i++) addr_d[i] = addr_q[i];
    et = 16'd0; nh = 8'd0; ihl = 6'd0; elen = 12'd0;
    bsel = 3'd0; o8 = 5'd0; o24 = 5'd0;
    case (phase_q)
      PH_ETH, PH_VLAN: begin
        if ((phase_q == PH_ETH && pos_q == 16'd12) || (phase_q == PH_VLAN && off == 16'd2))
          pnh_d = {b, 8'd0};
        if ((phase_q == PH_ETH && pos_q == 16'd13) ||
            (phase_q == PH_VLAN && off == 16'd3)) begin
          et = {pnh_q[15:8], b};
          pnh_d = et;
          if (et == EtVlan || et == EtQinq) begin
            if (cnt_q < VlanLim) begin
              cnt_d = cnt_q + 5'd1;
              phase_d = PH_VLAN; hstart_d = nxt; hend_d = nxt + 16'd4;
            end else phase_d = PH_REJECT;
          end else if (et == EtIpv4) begin
            kv6_d = 1'b0; phase_d = PH_V4; hstart_d = nxt; hend_d = nxt + 16'd20;
          end else if (et == EtIpv6) begin
            kv6_d = 1'b1; phase_d = PH_V6; hstart_d = nxt; hend_d = nxt + 16'd40;
          end else phase_d = PH_REJECT;
        end
      end
      PH_V4: begin
        if (off == 16'd0) sb_d = b;
        if (off == 16'd6) sw_d = {b, 8'd0};
        if (off == 16'd7) sw_d = {sw_q[15:8], b};
        if (off == 16'd9) kproto_d = b;
        bsel = 3'(off[1:0]);
        if (off >= 16'd12 && off <= 16'd15) addr_d[0][8*(7-bsel) +: 8] = b;
        if (off >= 16'd16 && off <= 16'd19) addr_d[2][8*(7-bsel) +: 8] = b;
        if (off == 16'd19) begin
          ihl = {sb_q[3:0], 2'b00};
          if (sb_q[7:4] != 4'd4 || ihl < 6'd20 ||
              (kproto_q != ProtoTcp && kproto_q != ProtoUdp &&
               kproto_q != ProtoEsp && kproto_q != ProtoGre))
            phase_d = PH_REJECT;
          else if (ihl > 6'd20) begin
            phase_d = PH_V4OPT; hend_d = hstart_q + 16'(ihl);
          end else if (sw_q[12:0] != 13'd0 || kproto_q == ProtoEsp || kproto_q == ProtoGre)
            phase_d = PH_DONE;
          else begin
            phase_d = PH_L4; hstart_d = nxt; hend_d = nxt + 16'd14;
          end
        end
      end
      PH_V4OPT: begin
        if (nxt == hend_q) begin
          if (sw_q[12:0] != 13'd0 || kproto_q == ProtoEsp || kproto_q == ProtoGre)
            phase_d = PH_DONE;
          else begin
            phase_d = PH_L4; hstart_d = nxt; hend_d = nxt + 16'd14;
          end
        end
      end
      PH_L4: begin
        if (off <= 16'd3) begin
          bsel = 3'(off[1:0]);
          pf_d[8*(4-bsel) +: 8] = b;
        end
        if (off == 16'd3) kports_d = 1'b1;
        if (off == 16'd13 && kproto_q == ProtoTcp) pf_d[7:0] = b;
      end
      default: begin
        // IPv6 fixed header and extension walk
        if (phase_q == PH_V6) begin
          if (off == 16'd0) sb_d = b;
          if (off == 16'd6) pnh_d = {8'd0, b};
          o8 = 5'(off - 16'd8);
          o24 = 5'(off - 16'd24);
          if (off >= 16'd8 && off <= 16'd23)
            addr_d[{1'b0, o8[3]}][8*(7-o8[2:0]) +: 8] = b;
          if (off >= 16'd24 && off <= 16'd39)
            addr_d[{1'b1, o24[3]}][8*(7-o24[2:0]) +: 8] = b;
          if (off == 16'd39) begin
            if (sb_q[7:4] != 4'd6) phase_d = PH_REJECT;
            else begin
              cnt_d = 5'd0;
              nh = pnh_q[7:0];
            end
          end
        end else if (phase_q == PH_V6FRAG) begin
          if (off == 16'd0) sb_d = b;
          if (off == 16'd2) sw_d = {b, 8'd0};
          if (off == 16'd3) sw_d = {sw_q[15:8], b};
          if (off == 16'd7) begin
            cnt_d = cnt_q + 5'd1;
            if (sw_q[15:3] != 13'd0) begin
              kproto_d = sb_q; phase_d = PH_DONE;
            end else begin
              pnh_d = {8'd0, sb_q}; nh = sb_q;
            end
          end
        end else if (phase_q == PH_V6EXT) begin
          if (off == 16'd0) sb_d = b;
          if (off == 16'd1) begin
            // length field of 255 gives 2048 bytes, hence 12 bits
            elen = (pnh_q == {8'd0, ProtoAh}) ? {2'b00, b, 2'b00} + 12'd8
                                              : {1'b0, b, 3'b000} + 12'd8;
            hend_d = hstart_q + 16'(elen);
          end
          if (off >= 16'd2 && nxt == hend_q) begin
            cnt_d = cnt_q + 5'd1;
            pnh_d = {8'd0, sb_q}; nh = sb_q;
          end
        end
        // shared next-header dispatch
        if ((phase_q == PH_V6 && off == 16'd39 && sb_q[7:4] == 4'd6) ||
            (phase_q == PH_V6FRAG && off == 16'd7 && sw_q[15:3] == 13'd0) ||
            (phase_q == PH_V6EXT && off >= 16'd2 && nxt == hend_q)) begin
          if (nh == ProtoTcp || nh == ProtoUdp) begin
            kproto_d = nh; phase_d = PH_L4; hstart_d = nxt; hend_d = nxt + 16'd14;
          end else if (cnt_d >= ExtLim) begin
            kproto_d = nh; phase_d = PH_DONE;
          end else if (nh == ProtoFrag) begin
            phase_d = PH_V6FRAG; hstart_d = nxt; hend_d = nxt + 16'd8;
          end else if (nh == ProtoHop || nh == ProtoRout || nh == ProtoDst ||
                       nh == ProtoAh) begin
            phase_d = PH_V6EXT; hstart_d = nxt; hend_d = nxt + 16'd8;
          end else begin
            kproto_d = nh; phase_d = PH_DONE;
          end
        end
      end
    endcase
    pos_d = (pos_q != 16'hFFFF) ? nxt : pos_q;

    // result from the updated state
    verdict = VerdictReject;
    ports   = 1'b0;
    proto_f = kproto_d;
    case (phase_d)
      PH_DONE: verdict = VerdictNoPorts;
      PH_L4: begin
        if (kports_d) begin
          verdict = VerdictPorts; ports = 1'b1;
        end else if (kv6_d) verdict = VerdictNoPorts;
      end
      PH_V6FRAG, PH_V6EXT: begin
        proto_f = pnh_d[7:0]; verdict = VerdictNoPorts;
      end
      default: verdict = VerdictReject;
    endcase
    res_o = '0;
    res_o.verdict = verdict;
    if (verdict != VerdictReject) begin
      res_o.ip_ver        = kv6_d ? 3'd6 : 3'd4;
      res_o.protocol      = proto_f;
      res_o.src_addr_high = addr_d[0];
      res_o.src_addr_low  = addr_d[1];
      res_o.dst_addr_high = addr_d[2];
      res_o.dst_addr_low  = addr_d[3];
      if (ports) begin
        res_o.src_port      = pf_d[39:24];
        res_o.dst_port      = pf_d[23:8];
        res_o.tcp_flag_bits = pf_d[7:0];
      end
    end
    res_o.frame_interface = intf_d;
    res_o.frame_len       = pos_d;
    res_valid_o = step_i && item_i.last_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ETH; pos_q <= '0; hend_q <= '0; hstart_q <= '0; pnh_q <= '0;
      cnt_q <= '0; pf_q <= '0; kv6_q <= 1'b0; kports_q <= 1'b0; kproto_q <= '0;
      sb_q <= '0; sw_q <= '0; intf_q <= '0;
      for (int i = 0; i < 4; i++) addr_q[i] <= '0;
    end else if (step_i) begin
      if (item_i.last_byte) begin
        phase_q <= PH_ETH; pos_q <= '0; hend_q <= '0; hstart_q <= '0; pnh_q <= '0;
        cnt_q <= '0; pf_q <= '0; kv6_q <= 1'b0; kports_q <= 1'b0; kproto_q <= '0;
        sb_q <= '0; sw_q <= '0; intf_q <= '0;
        for (int i = 0; i < 4; i++) addr_q[i] <= '0;
      end else begin
        phase_q <= phase_d; pos_q <= pos_d; hend_q <= hend_d; hstart_q <= hstart_d;
        pnh_q <= pnh_d; cnt_q <= cnt_d; pf_q <= pf_d; kv6_q <= kv6_d;
        kports_q <= kports_d; kproto_q <= kproto_d; sb_q <= sb_d; sw_q <= sw_d;
        intf_q <= intf_d;
        for (int i = 0; i < 4; i++) addr_q[i] <= addr_d[i];
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q)) else $error("phase not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.last_byte) |=> (pos_q == 16'd0 && phase_q == PH_ETH))
    else $error("frame state not cleared after last byte");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_VLAN) |-> (cnt_q <= VlanLim)) else $error("tag count over limit");
endmodule

### src/pfkp_out_reg.sv
// Output register with skid stage; accepts one more item while the output stalls.
// Depends on pfkp_pkg.
`timescale 1ns / 1ps
module pfkp_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  pfkp_pkg::out_item_t data_i,
  output logic                ready_o,
  output logic                valid_o,
  output pfkp_pkg::out_item_t data_o,
  input  logic                ready_i
);
  import pfkp_pkg::*;

  logic      full_q, skid_q;
  out_item_t main_q, skid_data_q;

  assign ready_o = !skid_q;
  assign valid_o = full_q;
  assign data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0; skid_q <= 1'b0;
    end else begin
      if (!full_q || ready_i) begin
        full_q <= skid_q || valid_i;
        skid_q <= 1'b0;
      end else if (valid_i && !skid_q) begin
        skid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!full_q || ready_i) main_q <= skid_q ? skid_data_q : data_i;
    if (valid_i && !skid_q) skid_data_q <= data_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_q |-> full_q) else $error("skid holds data while output empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_q && !ready_i && valid_i && !skid_q) |=> skid_q) else $error("request lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_q && !ready_i) |=> skid_q) else $error("skid dropped under stall");
endmodule

### src/packet_flow_key_parser.sv
// Top level of the packet flow key parser.
// Depends on pfkp_pkg, pfkp_if, pfkp_core and pfkp_out_reg.
//
// Usage: frame bytes enter on in_if, one request per byte in wire order, with
// last_byte set on the final byte and interface_index sampled with the first.
// One result request leaves on out_if per frame, after its last byte.
// Every byte is parsed by the phase logic in pfkp_core, so the block takes
// one byte per cycle while input ready is high; the result is registered in
// the output register when the last byte is accepted. A two-entry output
// register (main plus skid) decouples the sides: input stays ready while at
// most one result waits, and drops ready only when both entries hold results
// the sink has not taken. Reset (rst_ni low, asynchronous) clears the parse
// state to the Ethernet header phase and empties the output register.
`timescale 1ns / 1ps
module packet_flow_key_parser #(
  parameter int unsigned MaxVlanTags = pfkp_pkg::MaxVlanTagsDef,
  parameter int unsigned MaxIpv6Ext  = pfkp_pkg::MaxIpv6ExtDef
) (
  input logic       clk_i,
  input logic       rst_ni,
  pfkp_in_if.sink   in_if,
  pfkp_out_if.source out_if
);
  import pfkp_pkg::*;

  logic      step, res_valid, res_ready;
  out_item_t res;

  assign in_if.ready = res_ready;
  assign step = in_if.valid && res_ready;

  pfkp_core #(.MaxVlanTags(MaxVlanTags), .MaxIpv6Ext(MaxIpv6Ext)) u_core (
    .clk_i, .rst_ni, .step_i(step), .item_i(in_if.payload),
    .res_valid_o(res_valid), .res_o(res)
  );

  pfkp_out_reg u_out (
    .clk_i, .rst_ni, .valid_i(res_valid), .data_i(res), .ready_o(res_ready),
    .valid_o(out_if.valid), .data_o(out_if.payload), .ready_i(out_if.ready)
  );
endmodule

### tb/tb_packet_flow_key_parser.sv
// Self-checking bench for packet_flow_key_parser: directed and random Ethernet frames,
// byte-serial, with an in-bench flow key predictor and an in-order result scoreboard.
// Depends on pfkp_pkg, pfkp_if and the packet_flow_key_parser RTL.
`timescale 1ns / 1ps
module tb_packet_flow_key_parser;
  import pfkp_pkg::*;

  localparam int unsigned IdleLimit = 4000;

  typedef enum int {FK_NOISE, FK_V4, FK_V6, FK_OTHER} frame_kind_e;
  // IPv4 header variants
  localparam int V4Plain = 0, V4Opts = 1, V4Frag = 2, V4BadVer = 3, V4BadIhl = 4;

  typedef struct {
    frame_kind_e kind;
    int          ntags;
    int          proto;
    int          opt;    // IPv4 variant, or IPv6 extension count
    int          cut;    // truncate to this many bytes, 0 keeps the whole frame
    bit          typed;  // expected key is a reject, written in below
  } frame_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pfkp_in_if  in_ch ();
  pfkp_out_if out_ch ();

  packet_flow_key_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------- flow key predictor ----------------
  logic [15:0] pos_q, hstart_q, hend_q, nh_q, sword_q;
  phase_e      phase_q;
  logic [7:0]  count_q, kproto_q, sbyte_q;
  logic [63:0] addr_q [4];
  logic [39:0] pf_q;
  logic        kf_v6_q, kf_ports_q;
  logic [31:0] if_q;

  function automatic void clear_key();
    pos_q = '0; phase_q = PH_ETH; hend_q = '0; nh_q = '0; count_q = '0;
    for (int i = 0; i < 4; i++) addr_q[i] = '0;
    pf_q = '0; kf_v6_q = 1'b0; kf_ports_q = 1'b0; hstart_q = '0;
    kproto_q = '0; sbyte_q = '0; sword_q = '0; if_q = '0;
  endfunction

  function automatic void enter_hdr(phase_e p, int unsigned start, int unsigned len);
    phase_q = p;
    hstart_q = start[15:0];
    hend_q = 16'(start + len);
  endfunction

  function automatic void ethertype_step(int unsigned nxt);
    if (nh_q == EtVlan || nh_q == EtQinq) begin
      if (count_q < MaxVlanTagsDef) begin
        count_q++;
        enter_hdr(PH_VLAN, nxt, 4);
      end else begin
        phase_q = PH_REJECT;
      end
    end else if (nh_q == EtIpv4) begin
      kf_v6_q = 1'b0; kf_ports_q = 1'b0;
      enter_hdr(PH_V4, nxt, 20);
    end else if (nh_q == EtIpv6) begin
      kf_v6_q = 1'b1; kf_ports_q = 1'b0;
      enter_hdr(PH_V6, nxt, 40);
    end else begin
      phase_q = PH_REJECT;
    end
  endfunction

  function automatic void v6_step(int unsigned nxt);
    logic [7:0] nh;
    nh = nh_q[7:0];
    if (nh == ProtoTcp || nh == ProtoUdp) begin
      kproto_q = nh;
      enter_hdr(PH_L4, nxt, 14);
    end else if (count_q >= MaxIpv6ExtDef) begin
      kproto_q = nh;
      phase_q = PH_DONE;
    end else if (nh == ProtoFrag) begin
      enter_hdr(PH_V6FRAG, nxt, 8);
    end else if (nh == ProtoHop || nh == ProtoRout || nh == ProtoDst || nh == ProtoAh) begin
      enter_hdr(PH_V6EXT, nxt, 8);
    end else begin
      kproto_q = nh;
      phase_q = PH_DONE;
    end
  endfunction

  function automatic void v4_l4_step(int unsigned nxt);
    if (sword_q[12:0] != 0 || kproto_q == ProtoEsp || kproto_q == ProtoGre)
      phase_q = PH_DONE;
    else
      enter_hdr(PH_L4, nxt, 14);
  endfunction

  function automatic void parse_byte(int unsigned p, logic [7:0] b);
    int unsigned nxt, off, ihl, len, idx;
    nxt = p + 1;
    off = (p >= hstart_q) ? p - hstart_q : 0;
    case (phase_q)
      PH_ETH: begin
        if (p == 12) nh_q = {b, 8'h00};
        if (p == 13) begin
          nh_q[7:0] = b;
          ethertype_step(nxt);
        end
      end
      PH_VLAN: begin
        if (off == 2) nh_q = {b, 8'h00};
        if (off == 3) begin
          nh_q[7:0] = b;
          ethertype_step(nxt);
        end
      end
      PH_V4: begin
        if (off == 0) sbyte_q = b;
        if (off == 6) sword_q = {b, 8'h00};
        if (off == 7) sword_q[7:0] = b;
        if (off == 9) kproto_q = b;
        if (off >= 12 && off <= 15) addr_q[0] |= 64'(b) << (56 - 8 * (off - 12));
        if (off >= 16 && off <= 19) addr_q[2] |= 64'(b) << (56 - 8 * (off - 16));
        if (off == 19) begin
          ihl = sbyte_q[3:0] * 4;
          if (sbyte_q[7:4] != 4 || ihl < 20 ||
              !(kproto_q inside {ProtoTcp, ProtoUdp, ProtoEsp, ProtoGre})) begin
            phase_q = PH_REJECT;
          end else if (ihl > 20) begin
            phase_q = PH_V4OPT;
            hend_q = 16'(hstart_q + ihl);
          end else begin
            v4_l4_step(nxt);
          end
        end
      end
      PH_V4OPT: if (nxt == hend_q) v4_l4_step(nxt);
      PH_V6: begin
        if (off == 0) sbyte_q = b;
        if (off == 6) nh_q = {8'h00, b};
        if (off >= 8 && off <= 23) begin
          idx = off - 8;
          addr_q[idx >> 3] |= 64'(b) << (56 - 8 * (idx & 7));
        end
        if (off >= 24 && off <= 39) begin
          idx = off - 24;
          addr_q[2 + (idx >> 3)] |= 64'(b) << (56 - 8 * (idx & 7));
        end
        if (off == 39) begin
          if (sbyte_q[7:4] != 6) begin
            phase_q = PH_REJECT;
          end else begin
            count_q = '0;
            v6_step(nxt);
          end
        end
      end
      PH_V6FRAG: begin
        if (off == 0) sbyte_q = b;
        if (off == 2) sword_q = {b, 8'h00};
        if (off == 3) sword_q[7:0] = b;
        if (off == 7) begin
          count_q++;
          if (sword_q[15:3] != 0) begin
            kproto_q = sbyte_q;
            phase_q = PH_DONE;
          end else begin
            nh_q = {8'h00, sbyte_q};
            v6_step(nxt);
          end
        end
      end
      PH_V6EXT: begin
        if (off == 0) sbyte_q = b;
        if (off == 1) begin
          len = (nh_q == ProtoAh) ? (b + 2) * 4 : (b + 1) * 8;
          hend_q = 16'(hstart_q + len);
        end
        if (off >= 2 && nxt == hend_q) begin
          count_q++;
          nh_q = {8'h00, sbyte_q};
          v6_step(nxt);
        end
      end
      PH_L4: begin
        if (off <= 3) pf_q |= 40'(b) << (32 - 8 * off);
        if (off == 3) kf_ports_q = 1'b1;
        if (off == 13 && kproto_q == ProtoTcp) pf_q[7:0] |= b;
      end
      default: ;
    endcase
  endfunction

  // Returns 1 and the flow key when the byte closes the frame.
  function automatic bit predict_key(in_item_t it, output out_item_t key);
    int unsigned p;
    logic [1:0] verdict;
    bit ports;
    p = pos_q;
    verdict = VerdictReject;
    ports = 1'b0;
    key = '0;
    if (p == 0) if_q = it.interface_index;
    parse_byte(p, it.data_byte);
    if (pos_q != 16'hFFFF) pos_q++;
    if (!it.last_byte) return 1'b0;
    case (phase_q)
      PH_DONE: verdict = VerdictNoPorts;
      PH_L4: begin
        if (kf_ports_q) begin
          verdict = VerdictPorts;
          ports = 1'b1;
        end else if (kf_v6_q) begin
          verdict = VerdictNoPorts;
        end
      end
      PH_V6FRAG, PH_V6EXT: begin
        kproto_q = nh_q[7:0];
        verdict = VerdictNoPorts;
      end
      default: ;
    endcase
    key.verdict = verdict;
    if (verdict != VerdictReject) begin
      key.ip_ver = kf_v6_q ? 3'd6 : 3'd4;
      key.protocol = kproto_q;
      key.src_addr_high = addr_q[0];
      key.src_addr_low = addr_q[1];
      key.dst_addr_high = addr_q[2];
      key.dst_addr_low = addr_q[3];
      if (ports) begin
        key.src_port = pf_q[39:24];
        key.dst_port = pf_q[23:8];
        key.tcp_flag_bits = pf_q[7:0];
      end
    end
    key.frame_interface = if_q;
    key.frame_len = pos_q;
    clear_key();
    return 1'b1;
  endfunction

  // ---------------- scoreboard ----------------
  out_item_t   pending_keys [$];
  out_item_t   typed_keys [int];
  int          frames_sent = 0;
  int          frames_seen = 0;
  int          fail_count = 0;
  int unsigned idle_cycles = 0;

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    out_item_t key, got, want;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      if (predict_key(in_ch.payload, key)) begin
        if (typed_keys.exists(frames_seen)) key = typed_keys[frames_seen];
        pending_keys.push_back(key);
        frames_seen++;
      end
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      if (pending_keys.size() == 0) begin
        report("result with no frame pending, verdict", 64'(got.verdict), 64'd0);
      end else begin
        want = pending_keys.pop_front();
        if (got.verdict !== want.verdict)
          report("verdict", 64'(got.verdict), 64'(want.verdict));
        if (got.ip_ver !== want.ip_ver)
          report("ip_ver", 64'(got.ip_ver), 64'(want.ip_ver));
        if (got.protocol !== want.protocol)
          report("protocol", 64'(got.protocol), 64'(want.protocol));
        if (got.src_addr_high !== want.src_addr_high)
          report("src_addr_high", got.src_addr_high, want.src_addr_high);
        if (got.src_addr_low !== want.src_addr_low)
          report("src_addr_low", got.src_addr_low, want.src_addr_low);
        if (got.dst_addr_high !== want.dst_addr_high)
          report("dst_addr_high", got.dst_addr_high, want.dst_addr_high);
        if (got.dst_addr_low !== want.dst_addr_low)
          report("dst_addr_low", got.dst_addr_low, want.dst_addr_low);
        if (got.src_port !== want.src_port)
          report("src_port", 64'(got.src_port), 64'(want.src_port));
        if (got.dst_port !== want.dst_port)
          report("dst_port", 64'(got.dst_port), 64'(want.dst_port));
        if (got.tcp_flag_bits !== want.tcp_flag_bits)
          report("tcp_flag_bits", 64'(got.tcp_flag_bits), 64'(want.tcp_flag_bits));
        if (got.frame_interface !== want.frame_interface)
          report("frame_interface", 64'(got.frame_interface), 64'(want.frame_interface));
        if (got.frame_len !== want.frame_len)
          report("frame_len", 64'(got.frame_len), 64'(want.frame_len));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IdleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------- sink side stalls ----------------
  bit quiet = 1'b0;
  int ready_left = 0;

  // a stall is only started while ready is high, so a stall always follows a ready stretch
  always @(negedge clk_i) begin
    if (!rst_ni || quiet) begin
      out_ch.ready <= rst_ni;
    end else if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else if (out_ch.ready && $urandom_range(0, 2) == 0) begin
      out_ch.ready <= 1'b0;
      ready_left <= $urandom_range(0, 17);
    end else begin
      out_ch.ready <= 1'b1;
      ready_left <= $urandom_range(0, 40);
    end
  end

  // ---------------- frame builder ----------------
  logic [7:0] frame_q [$];

  function automatic void push16(logic [15:0] w);
    frame_q.push_back(w[15:8]);
    frame_q.push_back(w[7:0]);
  endfunction

  function automatic void push_rand(int n);
    for (int i = 0; i < n; i++) frame_q.push_back(8'($urandom));
  endfunction

  function automatic logic [7:0] pick_ext();
    case ($urandom_range(0, 4))
      0: return ProtoHop;
      1: return ProtoRout;
      2: return ProtoDst;
      3: return ProtoAh;
      default: return ProtoFrag;
    endcase
  endfunction

  function automatic void build_frame(frame_row_t r);
    logic [7:0] ext [$];
    logic [7:0] nxt;
    logic [15:0] et;
    int len;
    frame_q.delete();
    if (r.kind == FK_NOISE) begin
      push_rand($urandom_range(1, 40));
    end else begin
      push_rand(12);
      for (int i = 0; i < r.ntags; i++) begin
        push16($urandom_range(0, 1) ? EtVlan : EtQinq);
        push_rand(2);
      end
      case (r.kind)
        FK_V4: begin
          push16(EtIpv4);
          case (r.opt)
            V4Opts:   frame_q.push_back(8'h40 | 8'($urandom_range(6, 15)));
            V4BadVer: frame_q.push_back({4'($urandom_range(5, 15)), 4'h5});
            V4BadIhl: frame_q.push_back({4'h4, 4'($urandom_range(0, 4))});
            default:  frame_q.push_back(8'h45);
          endcase
          push_rand(5);
          if (r.opt == V4Frag) begin
            frame_q.push_back((8'($urandom) & 8'hE0) | 8'($urandom_range(0, 31)));
            frame_q.push_back(8'($urandom_range(1, 255)));
          end else begin
            frame_q.push_back(8'($urandom) & 8'hE0);
            frame_q.push_back(8'h00);
          end
          push_rand(1);
          frame_q.push_back(8'(r.proto));
          push_rand(10);
          if (r.opt == V4Opts) push_rand((frame_q[14 + 4 * r.ntags][3:0] - 5) * 4);
          push_rand(20);
        end
        FK_V6: begin
          push16(EtIpv6);
          for (int i = 0; i < r.opt; i++) ext.push_back(pick_ext());
          frame_q.push_back(8'h60 | 8'($urandom_range(0, 15)));
          push_rand(5);
          frame_q.push_back(ext.size() > 0 ? ext[0] : 8'(r.proto));
          push_rand(33);
          foreach (ext[i]) begin
            nxt = (i + 1 < ext.size()) ? ext[i + 1] : 8'(r.proto);
            frame_q.push_back(nxt);
            if (ext[i] == ProtoFrag) begin
              push_rand(1);
              // about a third are non-first fragments
              if ($urandom_range(0, 2) == 0) push16(16'($urandom_range(8, 65535)));
              else push16(16'($urandom_range(0, 7)));
              push_rand(4);
            end else begin
              len = $urandom_range(0, 2);
              frame_q.push_back(8'(len));
              push_rand((ext[i] == ProtoAh) ? (len + 2) * 4 - 2 : (len + 1) * 8 - 2);
            end
          end
          push_rand(20);
        end
        default: begin
          do et = 16'($urandom);
          while (et inside {EtIpv4, EtIpv6, EtVlan, EtQinq});
          push16(et);
          push_rand($urandom_range(0, 30));
        end
      endcase
      push_rand($urandom_range(0, 12));
    end
    if (r.cut > 0 && r.cut < frame_q.size()) frame_q = frame_q[0 : r.cut - 1];
  endfunction

  // ---------------- source side ----------------
  int bytes_sent = 0;

  task automatic send_frame(logic [31:0] ifx);
    foreach (frame_q[i]) begin
      if (!quiet && $urandom_range(0, 9) == 0) begin
        @(negedge clk_i);
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk_i);
      end else begin
        @(negedge clk_i);
      end
      in_ch.valid <= 1'b1;
      in_ch.payload <= '{data_byte: frame_q[i], last_byte: (i == frame_q.size() - 1),
                         interface_index: (i == 0) ? ifx : 32'($urandom)};
      do @(posedge clk_i); while (!in_ch.ready);
      bytes_sent++;
    end
    frames_sent++;
  endtask

  frame_row_t directed [] = '{
    '{FK_V4, 0, ProtoTcp, V4Plain, 0, 0},
    '{FK_V4, 0, ProtoUdp, V4Plain, 0, 0},
    '{FK_V4, 0, ProtoEsp, V4Plain, 0, 0},
    '{FK_V4, 1, ProtoGre, V4Plain, 0, 0},
    '{FK_V4, 0, ProtoTcp, V4Frag, 0, 0},
    '{FK_V4, 0, ProtoUdp, V4Opts, 0, 0},
    '{FK_V4, 0, ProtoTcp, V4BadVer, 0, 1},
    '{FK_V4, 0, ProtoTcp, V4BadIhl, 0, 1},
    '{FK_V4, 0, 1, V4Plain, 0, 1},
    '{FK_V4, 2, ProtoUdp, V4Plain, 0, 0},
    '{FK_V4, 3, ProtoTcp, V4Plain, 0, 1},
    '{FK_OTHER, 0, 0, 0, 0, 1},
    '{FK_NOISE, 0, 0, 0, 1, 1},
    '{FK_V4, 0, ProtoTcp, V4Plain, 20, 1},
    '{FK_V4, 0, ProtoTcp, V4Plain, 36, 1},
    '{FK_V4, 0, ProtoTcp, V4Plain, 47, 0},
    '{FK_V6, 0, ProtoTcp, 0, 0, 0},
    '{FK_V6, 0, ProtoUdp, 0, 56, 0},
    '{FK_V6, 1, ProtoTcp, 3, 0, 0},
    '{FK_V6, 0, 59, 0, 0, 0},
    '{FK_V6, 0, ProtoTcp, 9, 0, 0},
    '{FK_V6, 0, ProtoTcp, 1, 58, 0},
    '{FK_V6, 0, ProtoTcp, 0, 30, 1}
  };

  initial begin
    frame_row_t r;
    out_item_t rej;
    logic [31:0] ifx;
    clear_key();
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[k]) begin
      r = directed[k];
      ifx = (k % 2 == 0) ? 32'h0 : 32'hFFFF_FFFF;
      build_frame(r);
      if (r.typed) begin
        rej = '0;
        rej.verdict = VerdictReject;
        rej.frame_interface = ifx;
        rej.frame_len = 16'(frame_q.size());
        typed_keys[frames_sent] = rej;
      end
      send_frame(ifx);
    end

    while (bytes_sent < 1650) begin
      r.typed = 1'b0;
      r.cut = 0;
      case ($urandom_range(0, 19))
        0, 1:  r.kind = FK_NOISE;
        2:     r.kind = FK_OTHER;
        3, 4, 5, 6, 7, 8, 9, 10: r.kind = FK_V4;
        default: r.kind = FK_V6;
      endcase
      r.ntags = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      if (r.kind == FK_V4) begin
        case ($urandom_range(0, 9))
          0: r.proto = $urandom_range(0, 255);
          1: r.proto = ProtoEsp;
          2: r.proto = ProtoGre;
          3, 4, 5: r.proto = ProtoUdp;
          default: r.proto = ProtoTcp;
        endcase
        case ($urandom_range(0, 11))
          0: r.opt = V4BadVer;
          1: r.opt = V4BadIhl;
          2, 3: r.opt = V4Frag;
          4, 5: r.opt = V4Opts;
          default: r.opt = V4Plain;
        endcase
      end else begin
        r.proto = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                               : ($urandom_range(0, 1) ? ProtoTcp : ProtoUdp);
        r.opt = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 10) : $urandom_range(0, 3);
      end
      build_frame(r);
      // truncate some frames at a random point
      if ($urandom_range(0, 3) == 0) frame_q = frame_q[0 : $urandom_range(0, frame_q.size() - 1)];
      if ($urandom_range(0, 15) == 0) frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom);
      quiet = (bytes_sent > 1400);
      send_frame(32'($urandom));
    end

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
